// ----- hw/rtl/lrl_pkg.sv -----
package lrl_pkg;

    localparam int DEF_MAX_SEGMENTS = 64;
    localparam int DEF_SEQ_BITS     = 32;

    localparam logic [1:0] CMD_INS = 2'd0;
    localparam logic [1:0] CMD_REM = 2'd1;
    localparam logic [1:0] CMD_POP = 2'd2;

    typedef logic [3:0] t_mode;

    localparam t_mode MODE_IDLE      = 4'd0;
    localparam t_mode MODE_COMBINE   = 4'd1;
    localparam t_mode MODE_ABSORB    = 4'd2;
    localparam t_mode MODE_PLACE     = 4'd3;
    localparam t_mode MODE_DROP      = 4'd4;
    localparam t_mode MODE_SPLIT     = 4'd5;
    localparam t_mode MODE_TRIM      = 4'd6;
    localparam t_mode MODE_POP_SHIFT = 4'd7;
    localparam t_mode MODE_POP_INC   = 4'd8;

    typedef struct packed {
        logic        is_ins;
        t_mode       mode;
    } t_ctl;

    typedef struct packed {
        logic valid;
        logic merge;
        logic above;
        logic split;
        logic drop;
    } t_flags;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] range_low;
        logic [31:0] range_high;
    } t_in;

    typedef struct packed {
        logic [31:0] popped_seq;
        logic        popped_valid;
        logic [31:0] lost_total;
        logic [6:0]  segment_total;
        logic        table_overflow;
    } t_out;

endpackage

// ----- hw/rtl/loss_range_list_top.sv -----
// a request is registered on acceptance and worked on in the run state, and its
// result is registered when done; an insert combines joined ranges step by step, a
// remove drops whole ranges one by one; the cell row does one shift or rewrite per cycle
// a new request is taken only while idle and the result register is free
// reset (synchronous, active low) empties the list; range storage is not cleared
module loss_range_list_top #(
    parameter int MAX_SEGMENTS = lrl_pkg::DEF_MAX_SEGMENTS,
    parameter int SEQ_BITS     = lrl_pkg::DEF_SEQ_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  lrl_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output lrl_pkg::t_out o_out_data
);

    localparam int UW = $clog2(MAX_SEGMENTS + 1);
    localparam int XW = SEQ_BITS + 1;
    localparam logic [UW-1:0] MAX_U = UW'(MAX_SEGMENTS);
    localparam logic [XW-1:0] ONE_X = XW'(1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic                r_state, n_state;
    logic [1:0]          r_cmd;
    logic [SEQ_BITS-1:0] r_lo, r_hi;
    logic [UW-1:0]       r_used, n_used;
    logic [XW-1:0]       r_cnt, n_cnt;
    logic                r_ovalid;
    lrl_pkg::t_out       r_out;

    lrl_pkg::t_ctl       ctl;
    logic                accept, finish, ovf, pvalid, rev, full;
    logic [SEQ_BITS-1:0] pseq;
    logic [XW-1:0]       rng;
    logic [32:0]         cnt_w;
    logic any_merge, multi, any_drop, any_split;
    logic [XW-1:0] add_cmb, add_abs, sub_drop, sub_lo, sub_hi;

    logic [SEQ_BITS-1:0] c_f [MAX_SEGMENTS];
    logic [SEQ_BITS-1:0] c_l [MAX_SEGMENTS];
    lrl_pkg::t_flags     c_flags [MAX_SEGMENTS];
    logic [XW-1:0] c_add_cmb [MAX_SEGMENTS];
    logic [XW-1:0] c_add_abs [MAX_SEGMENTS];
    logic [XW-1:0] c_sub_drop [MAX_SEGMENTS];
    logic [XW-1:0] c_sub_lo [MAX_SEGMENTS];
    logic [XW-1:0] c_sub_hi [MAX_SEGMENTS];

    genvar gi;
    generate
        for (gi = 0; gi < MAX_SEGMENTS; gi++) begin : g_cell
            lrl_pkg::t_flags     p_flags;
            logic [SEQ_BITS-1:0] p_f, p_l, x_f, x_l;
            if (gi == 0) begin : g_first
                assign p_flags = '0;
                assign p_f     = '0;
                assign p_l     = '0;
            end else begin : g_mid
                assign p_flags = c_flags[gi-1];
                assign p_f     = c_f[gi-1];
                assign p_l     = c_l[gi-1];
            end
            if (gi == MAX_SEGMENTS - 1) begin : g_last
                assign x_f = '0;
                assign x_l = '0;
            end else begin : g_inner
                assign x_f = c_f[gi+1];
                assign x_l = c_l[gi+1];
            end
            lrl_cell #(
                .SEQ_BITS (SEQ_BITS),
                .UW       (UW),
                .IDX      (gi)
            ) u_cell (
                .i_clk        (i_clk),
                .i_ctl        (ctl),
                .i_lo         (r_lo),
                .i_hi         (r_hi),
                .i_used       (r_used),
                .i_prev_flags (p_flags),
                .i_prev_f     (p_f),
                .i_prev_l     (p_l),
                .i_next_f     (x_f),
                .i_next_l     (x_l),
                .o_f          (c_f[gi]),
                .o_l          (c_l[gi]),
                .o_flags      (c_flags[gi]),
                .o_add_cmb    (c_add_cmb[gi]),
                .o_add_abs    (c_add_abs[gi]),
                .o_sub_drop   (c_sub_drop[gi]),
                .o_sub_lo     (c_sub_lo[gi]),
                .o_sub_hi     (c_sub_hi[gi])
            );
        end
    endgenerate

    always_comb begin
        any_merge = 1'b0;
        multi     = 1'b0;
        any_drop  = 1'b0;
        any_split = 1'b0;
        add_cmb   = '0;
        add_abs   = '0;
        sub_drop  = '0;
        sub_lo    = '0;
        sub_hi    = '0;
        for (int i = 0; i < MAX_SEGMENTS; i++) begin
            any_merge = any_merge | c_flags[i].merge;
            any_drop  = any_drop | c_flags[i].drop;
            any_split = any_split | c_flags[i].split;
            add_cmb   = add_cmb | c_add_cmb[i];
            add_abs   = add_abs | c_add_abs[i];
            sub_drop  = sub_drop | c_sub_drop[i];
            sub_lo    = sub_lo | c_sub_lo[i];
            sub_hi    = sub_hi | c_sub_hi[i];
        end
        for (int i = 1; i < MAX_SEGMENTS; i++) begin
            multi = multi | (c_flags[i].merge & c_flags[i-1].merge);
        end
    end

    assign o_in_ready = (r_state == S_IDLE) && (!r_ovalid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;
    assign rev        = r_lo > r_hi;
    assign full       = r_used == MAX_U;
    assign rng        = {1'b0, r_hi} - {1'b0, r_lo} + ONE_X;

    always_comb begin
        ctl.is_ins = r_cmd == lrl_pkg::CMD_INS;
        ctl.mode   = lrl_pkg::MODE_IDLE;
        finish     = 1'b0;
        ovf        = 1'b0;
        pvalid     = 1'b0;
        pseq       = '0;
        n_used     = r_used;
        n_cnt      = r_cnt;
        n_state    = r_state;
        if (r_state == S_IDLE) begin
            if (accept) begin
                n_state = S_RUN;
            end
        end else begin
            unique case (r_cmd)
                lrl_pkg::CMD_INS: begin
                    if (rev) begin
                        finish = 1'b1;
                    end else if (any_merge) begin
                        if (multi) begin
                            ctl.mode = lrl_pkg::MODE_COMBINE;
                            n_used   = r_used - 1'b1;
                            n_cnt    = r_cnt + add_cmb;
                        end else begin
                            ctl.mode = lrl_pkg::MODE_ABSORB;
                            n_cnt    = r_cnt + add_abs;
                            finish   = 1'b1;
                        end
                    end else if (full) begin
                        ovf    = 1'b1;
                        finish = 1'b1;
                    end else begin
                        ctl.mode = lrl_pkg::MODE_PLACE;
                        n_used   = r_used + 1'b1;
                        n_cnt    = r_cnt + rng;
                        finish   = 1'b1;
                    end
                end
                lrl_pkg::CMD_REM: begin
                    if (rev) begin
                        finish = 1'b1;
                    end else if (any_drop) begin
                        ctl.mode = lrl_pkg::MODE_DROP;
                        n_used   = r_used - 1'b1;
                        n_cnt    = r_cnt - sub_drop;
                    end else if (any_split) begin
                        finish = 1'b1;
                        if (full) begin
                            ovf = 1'b1;
                        end else begin
                            ctl.mode = lrl_pkg::MODE_SPLIT;
                            n_used   = r_used + 1'b1;
                            n_cnt    = r_cnt - rng;
                        end
                    end else begin
                        ctl.mode = lrl_pkg::MODE_TRIM;
                        n_cnt    = r_cnt - sub_lo - sub_hi;
                        finish   = 1'b1;
                    end
                end
                lrl_pkg::CMD_POP: begin
                    finish = 1'b1;
                    if (r_used != '0) begin
                        pvalid = 1'b1;
                        pseq   = c_f[0];
                        n_cnt  = r_cnt - ONE_X;
                        if (c_f[0] == c_l[0]) begin
                            ctl.mode = lrl_pkg::MODE_POP_SHIFT;
                            n_used   = r_used - 1'b1;
                        end else begin
                            ctl.mode = lrl_pkg::MODE_POP_INC;
                        end
                    end
                end
                default: begin
                    finish = 1'b1;
                end
            endcase
            if (finish) begin
                n_state = S_IDLE;
            end
        end
    end

    assign cnt_w = 33'(n_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_used   <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_cnt   <= n_cnt;
            if (finish) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_in_data.cmd;
            r_lo  <= i_in_data.range_low[SEQ_BITS-1:0];
            r_hi  <= i_in_data.range_high[SEQ_BITS-1:0];
        end
        if (finish) begin
            r_out.popped_seq     <= 32'(pseq);
            r_out.popped_valid   <= pvalid;
            r_out.lost_total     <= cnt_w[32] ? 32'hFFFF_FFFF : cnt_w[31:0];
            r_out.segment_total  <= 7'(n_used);
            r_out.table_overflow <= ovf;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= MAX_U)
        else $error("segment count beyond capacity");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used == '0) |-> (r_cnt == '0))
        else $error("empty list holds numbers");

    a_count_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_used == '0))
        else $error("stored ranges with zero count");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_out.table_overflow) |-> (r_used == MAX_U))
        else $error("overflow reported with free slots");

    a_pop_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_out.popped_valid) |-> (r_cmd == lrl_pkg::CMD_POP))
        else $error("popped number on a non-pop request");

endmodule

// ----- hw/rtl/lrl_cell.sv -----
module lrl_cell #(
    parameter int SEQ_BITS = lrl_pkg::DEF_SEQ_BITS,
    parameter int UW       = 7,
    parameter int IDX      = 0
) (
    input  logic                 i_clk,
    input  lrl_pkg::t_ctl        i_ctl,
    input  logic [SEQ_BITS-1:0]  i_lo,
    input  logic [SEQ_BITS-1:0]  i_hi,
    input  logic [UW-1:0]        i_used,
    input  lrl_pkg::t_flags      i_prev_flags,
    input  logic [SEQ_BITS-1:0]  i_prev_f,
    input  logic [SEQ_BITS-1:0]  i_prev_l,
    input  logic [SEQ_BITS-1:0]  i_next_f,
    input  logic [SEQ_BITS-1:0]  i_next_l,
    output logic [SEQ_BITS-1:0]  o_f,
    output logic [SEQ_BITS-1:0]  o_l,
    output lrl_pkg::t_flags      o_flags,
    output logic [SEQ_BITS:0]    o_add_cmb,
    output logic [SEQ_BITS:0]    o_add_abs,
    output logic [SEQ_BITS:0]    o_sub_drop,
    output logic [SEQ_BITS:0]    o_sub_lo,
    output logic [SEQ_BITS:0]    o_sub_hi
);

    localparam int XW = SEQ_BITS + 1;
    localparam logic [UW-1:0] MY_IDX = UW'(IDX);
    localparam logic [XW-1:0] ONE_X  = XW'(1);

    logic [SEQ_BITS-1:0] r_f, r_l, n_f, n_l;
    logic [XW-1:0] fx, lx, lox, hix, nfx, nlx;
    logic [XW-1:0] sz_self, sz_next, sz_cmb, sz_abs;
    logic [SEQ_BITS-1:0] u_f, u_l_abs, u_l_cmb;
    logic valid, at_end, below_i, above_i, ins_merge;
    logic below_r, above_r, hit, drop, split, lowtrim, hightrim;
    logic first_merge;
    lrl_pkg::t_flags flags;

    always_comb begin
        fx  = {1'b0, r_f};
        lx  = {1'b0, r_l};
        lox = {1'b0, i_lo};
        hix = {1'b0, i_hi};
        nfx = {1'b0, i_next_f};
        nlx = {1'b0, i_next_l};
        valid  = MY_IDX < i_used;
        at_end = MY_IDX == i_used;

        below_i   = (lx + ONE_X) < lox;
        above_i   = fx > (hix + ONE_X);
        ins_merge = valid && !below_i && !above_i;

        below_r  = r_l < i_lo;
        above_r  = r_f > i_hi;
        hit      = valid && !below_r && !above_r;
        drop     = hit && (r_f >= i_lo) && (r_l <= i_hi);
        split    = hit && (r_f < i_lo) && (r_l > i_hi);
        lowtrim  = hit && (r_f < i_lo) && (r_l <= i_hi);
        hightrim = hit && (r_f >= i_lo) && (r_l > i_hi);

        flags.valid = valid;
        flags.merge = i_ctl.is_ins && ins_merge;
        flags.above = valid && (i_ctl.is_ins ? above_i : above_r);
        flags.split = !i_ctl.is_ins && split;
        flags.drop  = !i_ctl.is_ins && drop;
        first_merge = flags.merge && !i_prev_flags.merge;

        u_f     = (r_f < i_lo) ? r_f : i_lo;
        u_l_abs = (r_l > i_hi) ? r_l : i_hi;
        u_l_cmb = (i_next_l > i_hi) ? i_next_l : i_hi;

        sz_self = lx - fx + ONE_X;
        sz_next = nlx - nfx + ONE_X;
        sz_cmb  = {1'b0, u_l_cmb} - {1'b0, u_f} + ONE_X;
        sz_abs  = {1'b0, u_l_abs} - {1'b0, u_f} + ONE_X;

        o_add_cmb  = first_merge ? (sz_cmb - sz_self - sz_next) : '0;
        o_add_abs  = first_merge ? (sz_abs - sz_self) : '0;
        o_sub_drop = (flags.drop && !i_prev_flags.drop) ? sz_self : '0;
        o_sub_lo   = (!i_ctl.is_ins && lowtrim) ? (lx - lox + ONE_X) : '0;
        o_sub_hi   = (!i_ctl.is_ins && hightrim) ? (hix - fx + ONE_X) : '0;
    end

    always_comb begin
        n_f = r_f;
        n_l = r_l;
        unique case (i_ctl.mode)
            lrl_pkg::MODE_COMBINE: begin
                if (first_merge) begin
                    n_f = u_f;
                    n_l = u_l_cmb;
                end else if (valid && !below_i) begin
                    n_f = i_next_f;
                    n_l = i_next_l;
                end
            end
            lrl_pkg::MODE_ABSORB: begin
                if (flags.merge) begin
                    n_f = u_f;
                    n_l = u_l_abs;
                end
            end
            lrl_pkg::MODE_PLACE: begin
                if (flags.above || at_end) begin
                    if (i_prev_flags.above) begin
                        n_f = i_prev_f;
                        n_l = i_prev_l;
                    end else begin
                        n_f = i_lo;
                        n_l = i_hi;
                    end
                end
            end
            lrl_pkg::MODE_DROP: begin
                if (valid && (r_f >= i_lo)) begin
                    n_f = i_next_f;
                    n_l = i_next_l;
                end
            end
            lrl_pkg::MODE_SPLIT: begin
                if (flags.split) begin
                    n_l = i_lo - 1'b1;
                end else if (flags.above || at_end) begin
                    if (i_prev_flags.split) begin
                        n_f = i_hi + 1'b1;
                        n_l = i_prev_l;
                    end else if (i_prev_flags.above) begin
                        n_f = i_prev_f;
                        n_l = i_prev_l;
                    end
                end
            end
            lrl_pkg::MODE_TRIM: begin
                if (lowtrim) begin
                    n_l = i_lo - 1'b1;
                end else if (hightrim) begin
                    n_f = i_hi + 1'b1;
                end
            end
            lrl_pkg::MODE_POP_SHIFT: begin
                n_f = i_next_f;
                n_l = i_next_l;
            end
            lrl_pkg::MODE_POP_INC: begin
                if (MY_IDX == '0) begin
                    n_f = r_f + 1'b1;
                end
            end
            default: begin
                n_f = r_f;
                n_l = r_l;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_f <= n_f;
        r_l <= n_l;
    end

    assign o_f     = r_f;
    assign o_l     = r_l;
    assign o_flags = flags;

endmodule

// ----- tb/tb_loss_range_list_top.sv -----
`timescale 1ns / 100ps

module tb_loss_range_list_top;

    localparam int SEGS = lrl_pkg::DEF_MAX_SEGMENTS;
    localparam logic [1:0] CMD_NONE = 2'd3;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    lrl_pkg::t_in i_in_data;
    logic o_out_valid;
    logic i_out_ready;
    lrl_pkg::t_out o_out_data;

    loss_range_list_top u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_data(i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data(o_out_data)
    );

    // predicted loss list
    bit [63:0] lost_first [SEGS];
    bit [63:0] lost_last [SEGS];
    int lost_segs;
    bit [63:0] lost_sum;
    bit [63:0] work_first [SEGS + 2];
    bit [63:0] work_last [SEGS + 2];

    lrl_pkg::t_in pending_reqs[$];
    lrl_pkg::t_out expected_results[$];
    int errors;
    logic in_fire;
    int in_gap;
    int out_stall;
    bit calm;

    always #5 i_clk = ~i_clk;

    function automatic bit commit_list(int n);
        bit [63:0] total;
        total = 0;
        if (n > SEGS) return 1'b1;
        for (int i = 0; i < n; i++) begin
            lost_first[i] = work_first[i];
            lost_last[i] = work_last[i];
            total += work_last[i] - work_first[i] + 1;
        end
        lost_segs = n;
        lost_sum = total;
        return 1'b0;
    endfunction

    function automatic bit merge_range(bit [63:0] lo, bit [63:0] hi);
        int n;
        bit placed;
        bit [63:0] nf;
        bit [63:0] nl;
        n = 0;
        placed = 0;
        nf = lo;
        nl = hi;
        for (int i = 0; i < lost_segs; i++) begin
            if (lost_last[i] + 1 < nf) begin
                work_first[n] = lost_first[i]; work_last[n] = lost_last[i]; n++;
            end else if (lost_first[i] > nl + 1) begin
                if (!placed) begin
                    work_first[n] = nf; work_last[n] = nl; n++;
                    placed = 1;
                end
                work_first[n] = lost_first[i]; work_last[n] = lost_last[i]; n++;
            end else begin
                if (lost_first[i] < nf) nf = lost_first[i];
                if (lost_last[i] > nl) nl = lost_last[i];
            end
        end
        if (!placed) begin
            work_first[n] = nf; work_last[n] = nl; n++;
        end
        return commit_list(n);
    endfunction

    function automatic bit cut_range(bit [63:0] lo, bit [63:0] hi);
        int n;
        n = 0;
        for (int i = 0; i < lost_segs; i++) begin
            if (lost_last[i] < lo || lost_first[i] > hi) begin
                work_first[n] = lost_first[i]; work_last[n] = lost_last[i]; n++;
            end else begin
                if (lost_first[i] < lo) begin
                    work_first[n] = lost_first[i]; work_last[n] = lo - 1; n++;
                end
                if (lost_last[i] > hi) begin
                    work_first[n] = hi + 1; work_last[n] = lost_last[i]; n++;
                end
            end
        end
        return commit_list(n);
    endfunction

    function automatic lrl_pkg::t_out apply_request(lrl_pkg::t_in req);
        lrl_pkg::t_out res;
        bit [63:0] lo;
        bit [63:0] hi;
        res = '0;
        lo = req.range_low;
        hi = req.range_high;
        case (req.cmd)
            lrl_pkg::CMD_INS: if (lo <= hi) res.table_overflow = merge_range(lo, hi);
            lrl_pkg::CMD_REM: if (lo <= hi) res.table_overflow = cut_range(lo, hi);
            lrl_pkg::CMD_POP: begin
                if (lost_segs > 0) begin
                    res.popped_seq = lost_first[0][31:0];
                    res.popped_valid = 1'b1;
                    if (lost_first[0] == lost_last[0]) begin
                        for (int i = 1; i < lost_segs; i++) begin
                            lost_first[i - 1] = lost_first[i];
                            lost_last[i - 1] = lost_last[i];
                        end
                        lost_segs--;
                    end else begin
                        lost_first[0] = lost_first[0] + 1;
                    end
                    lost_sum = lost_sum - 1;
                end
            end
            default: ;
        endcase
        res.lost_total = (lost_sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : lost_sum[31:0];
        res.segment_total = 7'(lost_segs);
        return res;
    endfunction

    function automatic int pick_gap();
        if (calm) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(5, 40);
        return $urandom_range(0, 2);
    endfunction

    task automatic add_req(logic [1:0] cmd, logic [31:0] lo, logic [31:0] hi);
        lrl_pkg::t_in r;
        r.cmd = cmd;
        r.range_low = lo;
        r.range_high = hi;
        pending_reqs = {pending_reqs, r};
    endtask

    // accept, predict and check
    always @(posedge i_clk) begin
        lrl_pkg::t_out exp_res;
        in_fire <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready)
            expected_results = {expected_results, apply_request(i_in_data)};
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $error("result with nothing expected: %p", o_out_data);
                errors++;
            end else begin
                exp_res = expected_results.pop_front();
                if (o_out_data.popped_seq !== exp_res.popped_seq) begin
                    $error("popped_seq exp %h got %h", exp_res.popped_seq,
                           o_out_data.popped_seq);
                    errors++;
                end
                if (o_out_data.popped_valid !== exp_res.popped_valid) begin
                    $error("popped_valid exp %b got %b", exp_res.popped_valid,
                           o_out_data.popped_valid);
                    errors++;
                end
                if (o_out_data.lost_total !== exp_res.lost_total) begin
                    $error("lost_total exp %h got %h", exp_res.lost_total,
                           o_out_data.lost_total);
                    errors++;
                end
                if (o_out_data.segment_total !== exp_res.segment_total) begin
                    $error("segment_total exp %0d got %0d", exp_res.segment_total,
                           o_out_data.segment_total);
                    errors++;
                end
                if (o_out_data.table_overflow !== exp_res.table_overflow) begin
                    $error("table_overflow exp %b got %b", exp_res.table_overflow,
                           o_out_data.table_overflow);
                    errors++;
                end
            end
        end
    end

    // request driver
    always @(negedge i_clk) begin
        logic next_valid;
        lrl_pkg::t_in next_data;
        next_valid = i_in_valid;
        next_data = i_in_data;
        if (i_rst_n && (!i_in_valid || in_fire)) begin
            next_valid = 1'b0;
            if (in_gap > 0) begin
                in_gap--;
            end else if (pending_reqs.size() > 0) begin
                next_data = pending_reqs.pop_front();
                next_valid = 1'b1;
                in_gap = pick_gap();
            end
        end
        i_in_valid <= next_valid;
        i_in_data <= next_data;
    end

    // result back-pressure
    always @(negedge i_clk) begin
        if (out_stall > 0) begin
            out_stall--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            out_stall = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if ($urandom_range(0, 299) == 0) calm <= ~calm;
    end

    initial begin
        int total;
        int sel;
        int n;
        logic [31:0] base;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [1:0] cmd;

        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b0;
        in_fire = 1'b0;
        in_gap = 0;
        out_stall = 0;
        calm = 1'b0;
        errors = 0;
        lost_segs = 0;
        lost_sum = 0;

        add_req(lrl_pkg::CMD_POP, 32'h0, 32'h0);
        add_req(lrl_pkg::CMD_INS, 32'h0, 32'h0);
        add_req(lrl_pkg::CMD_INS, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_req(lrl_pkg::CMD_INS, 32'd2, 32'd5);
        add_req(lrl_pkg::CMD_INS, 32'd7, 32'd9);
        add_req(lrl_pkg::CMD_INS, 32'd6, 32'd6);
        add_req(lrl_pkg::CMD_INS, 32'd20, 32'd10);
        add_req(lrl_pkg::CMD_REM, 32'd3, 32'd4);
        add_req(lrl_pkg::CMD_REM, 32'd9, 32'd8);
        add_req(lrl_pkg::CMD_POP, 32'h0, 32'h0);
        add_req(lrl_pkg::CMD_POP, 32'h0, 32'h0);
        add_req(CMD_NONE, 32'hFFFF_FFFF, 32'h0);
        add_req(lrl_pkg::CMD_INS, 32'h0, 32'hFFFF_FFFF);
        add_req(lrl_pkg::CMD_POP, 32'h0, 32'h0);
        add_req(lrl_pkg::CMD_REM, 32'h5555_5555, 32'hAAAA_AAAA);
        add_req(lrl_pkg::CMD_REM, 32'h0, 32'hFFFF_FFFF);
        add_req(lrl_pkg::CMD_POP, 32'h0, 32'h0);
        add_req(lrl_pkg::CMD_INS, 32'd100, 32'd200);
        add_req(lrl_pkg::CMD_REM, 32'd150, 32'd150);
        add_req(lrl_pkg::CMD_REM, 32'd90, 32'd120);
        add_req(lrl_pkg::CMD_REM, 32'd190, 32'd300);
        add_req(lrl_pkg::CMD_INS, 32'd100, 32'd300);
        add_req(lrl_pkg::CMD_REM, 32'h0, 32'hFFFF_FFFF);

        total = 0;
        while (total < 700) begin
            sel = $urandom_range(0, 9);
            base = $urandom_range(0, 32'hFFFF_F000);
            if (sel == 0) begin
                // fill the table or nearly so, then try to overflow it by insert and by a remove that may split
                n = $urandom_range(62, 67);
                for (int k = 0; k < n; k++)
                    add_req(lrl_pkg::CMD_INS, base + 4 * k, base + 4 * k + 2);
                add_req(lrl_pkg::CMD_INS, base + 4 * n + 8, base + 4 * n + 9);
                add_req(lrl_pkg::CMD_REM, base + 4 * $urandom_range(0, 60) + 1,
                        base + 4 * $urandom_range(0, 60) + 1);
                for (int k = 0; k < 5; k++) add_req(lrl_pkg::CMD_POP, 32'h0, 32'h0);
                add_req(lrl_pkg::CMD_REM, base, base + 4 * n + 16);
                total += n + 8;
            end else if (sel == 1) begin
                for (int k = 0; k < 10; k++) begin
                    cmd = 2'($urandom_range(0, 3));
                    lo = $urandom;
                    hi = $urandom;
                    if (lo > hi && $urandom_range(0, 3) != 0) add_req(cmd, hi, lo);
                    else add_req(cmd, lo, hi);
                end
                total += 10;
            end else begin
                for (int k = 0; k < 30; k++) begin
                    sel = $urandom_range(0, 99);
                    if (sel < 45) cmd = lrl_pkg::CMD_INS;
                    else if (sel < 75) cmd = lrl_pkg::CMD_REM;
                    else if (sel < 95) cmd = lrl_pkg::CMD_POP;
                    else cmd = CMD_NONE;
                    lo = base + $urandom_range(0, 200);
                    hi = lo + $urandom_range(0, 20);
                    if ($urandom_range(0, 19) == 0) add_req(cmd, hi + 1, lo);
                    else add_req(cmd, lo, hi);
                end
                total += 30;
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_reqs.size() == 0);
        @(posedge i_clk);
        while (i_in_valid || expected_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0)
            $display("tb_loss_range_list_top: PASS");
        else
            $display("tb_loss_range_list_top: FAIL");
        $finish;
    end

    initial begin
        #20ms;
        $display("tb_loss_range_list_top: FAIL");
        $finish;
    end

endmodule
